/* hw/rtl/prs_pkg.sv */
// Shared types and constants for the polynomial root solver.
// No dependencies; every other file imports this package.
package prs_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusZeroLead = 2'd1,
    StatusSat      = 2'd2
  } status_e;

  typedef struct packed {
    logic                        func;
    logic signed [DataWidth-1:0] coef_a;
    logic signed [DataWidth-1:0] coef_b;
    logic signed [DataWidth-1:0] coef_c;
  } prs_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] root_one;
    logic signed [DataWidth-1:0] root_two;
    logic                        is_complex;
    status_e                     status;
  } prs_out_t;

endpackage

/* hw/rtl/prs_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on prs_pkg; carries a sideband vector alongside each operand.
module prs_sqrt import prs_pkg::*; #(
  parameter int RW = DataWidth + 1,
  parameter int SW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [2*RW-1:0]   x_i,
  input  logic [SW-1:0]     side_i,
  output logic              vld_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     side_o
);

  localparam int XW = 2 * RW;

  logic [XW-1:0] x_q    [1:RW];
  logic [RW+1:0] rem_q  [1:RW];
  logic [RW-1:0] root_q [1:RW];
  logic [SW-1:0] side_q [1:RW];
  logic          vld_q  [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [XW-1:0] cur_x;
    logic [RW+1:0] cur_rem;
    logic [RW-1:0] cur_root;
    logic [SW-1:0] cur_side;
    logic          cur_vld;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign cur_x    = x_i;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = side_i;
      assign cur_vld  = vld_i;
    end else begin : g_next
      assign cur_x    = x_q[k];
      assign cur_rem  = rem_q[k];
      assign cur_root = root_q[k];
      assign cur_side = side_q[k];
      assign cur_vld  = vld_q[k];
    end

    // bring down two bits and try the next root bit
    assign rem_sh = (RW+2)'({cur_rem, cur_x[XW-1:XW-2]});
    assign trial  = (RW+2)'({cur_root, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1]    <= cur_x << 2;
        rem_q[k+1]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k+1] <= RW'({cur_root, ge});
        side_q[k+1] <= cur_side;
      end
    end
  end

  assign vld_o  = vld_q[RW];
  assign root_o = root_q[RW];
  assign side_o = side_q[RW];

endmodule

/* hw/rtl/prs_div.sv */
// Pipelined dual restoring divider: two numerators over one divisor,
// one quotient bit per register stage. Depends on prs_pkg.
module prs_div import prs_pkg::*; #(
  parameter int NW = DataWidth + 2 + FracBits,
  parameter int DW = DataWidth + 1,
  parameter int SW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_a_i,
  input  logic [NW-1:0] num_b_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_a_o,
  output logic [NW-1:0] quo_b_o,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] na_q   [1:NW];
  logic [NW-1:0] nb_q   [1:NW];
  logic [DW-1:0] ra_q   [1:NW];
  logic [DW-1:0] rb_q   [1:NW];
  logic [NW-1:0] qa_q   [1:NW];
  logic [NW-1:0] qb_q   [1:NW];
  logic [DW-1:0] den_q  [1:NW];
  logic [SW-1:0] side_q [1:NW];
  logic          vld_q  [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] cna, cnb, cqa, cqb;
    logic [DW-1:0] cra, crb, cden;
    logic [SW-1:0] cside;
    logic          cvld;
    logic [DW:0]   sha, shb;
    logic          gea, geb;

    if (k == 0) begin : g_first
      assign cna   = num_a_i;
      assign cnb   = num_b_i;
      assign cqa   = '0;
      assign cqb   = '0;
      assign cra   = '0;
      assign crb   = '0;
      assign cden  = den_i;
      assign cside = side_i;
      assign cvld  = vld_i;
    end else begin : g_next
      assign cna   = na_q[k];
      assign cnb   = nb_q[k];
      assign cqa   = qa_q[k];
      assign cqb   = qb_q[k];
      assign cra   = ra_q[k];
      assign crb   = rb_q[k];
      assign cden  = den_q[k];
      assign cside = side_q[k];
      assign cvld  = vld_q[k];
    end

    // shift in the next numerator bit and subtract where it fits
    assign sha = {cra, cna[NW-1]};
    assign shb = {crb, cnb[NW-1]};
    assign gea = sha >= {1'b0, cden};
    assign geb = shb >= {1'b0, cden};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= cvld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        na_q[k+1]   <= cna << 1;
        nb_q[k+1]   <= cnb << 1;
        ra_q[k+1]   <= DW'(gea ? sha - {1'b0, cden} : sha);
        rb_q[k+1]   <= DW'(geb ? shb - {1'b0, cden} : shb);
        qa_q[k+1]   <= NW'({cqa, gea});
        qb_q[k+1]   <= NW'({cqb, geb});
        den_q[k+1]  <= cden;
        side_q[k+1] <= cside;
      end
    end
  end

  assign vld_o   = vld_q[NW];
  assign quo_a_o = qa_q[NW];
  assign quo_b_o = qb_q[NW];
  assign side_o  = side_q[NW];

endmodule

/* hw/rtl/polynomial_root_solver_top.sv */
// Polynomial root solver: linear and quadratic equations in signed fixed point.
// Pipeline: decode, multiply, discriminant, DATA_WIDTH+1 square-root stages, numerator,
// DATA_WIDTH+FRAC_BITS+2 divider stages, output register. Throughput: one equation per
// cycle while the output is not stalled.
// The whole pipeline holds while a result waits at the output.
// Reset clears all valid bits; data registers are not reset.
module polynomial_root_solver_top import prs_pkg::*; #(
  parameter int DATA_WIDTH = DataWidth,
  parameter int FRAC_BITS  = FracBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  prs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output prs_out_t out_data_o
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int RW = W + 1;
  localparam int XW = 2 * RW;
  localparam int MW = W + 2;
  localparam int NW = MW + F;
  localparam int DW = W + 1;
  localparam int SW = 5 + 2 * W;

  logic en;
  logic out_valid_q;
  prs_out_t out_q;

  // advance everything whenever the output register is free or drains
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // signed-magnitude add; zero is non-negative
  function automatic logic [MW:0] sm_add(logic s_a, logic [MW-1:0] m_a,
                                         logic s_b, logic [MW-1:0] m_b);
    logic          s;
    logic [MW-1:0] m;
    if (s_a == s_b) begin
      s = s_a;
      m = m_a + m_b;
    end else if (m_a >= m_b) begin
      s = s_a;
      m = m_a - m_b;
    end else begin
      s = s_b;
      m = m_b - m_a;
    end
    if (m == '0) s = 1'b0;
    return {s, m};
  endfunction

  // saturate a quotient magnitude and apply its sign; top bit flags saturation
  function automatic logic [W:0] sat_sign(logic neg, logic [NW-1:0] q);
    logic [NW-1:0] lim;
    logic [NW-1:0] mag;
    logic          over;
    lim  = (NW'(1) << (W - 1)) - NW'(!neg);
    over = q > lim;
    mag  = over ? lim : q;
    return {over, neg ? W'(-mag[W-1:0]) : mag[W-1:0]};
  endfunction

  // ---------------- stage 1: decode ----------------
  logic [W-1:0] a_v, b_v, c_v;
  logic         sa_c, sb_c, sc_c;
  assign a_v  = W'(in_data_i.coef_a);
  assign b_v  = W'(in_data_i.coef_b);
  assign c_v  = W'(in_data_i.coef_c);
  assign sa_c = a_v[W-1];
  assign sb_c = b_v[W-1];
  assign sc_c = c_v[W-1];

  logic         v1_q, quad1_q, sa1_q, sc1_q, nb1_q, zero1_q;
  logic [W-1:0] ma1_q, mb1_q, mc1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quad1_q <= in_data_i.func;
      sa1_q   <= sa_c;
      sc1_q   <= sc_c;
      nb1_q   <= (b_v != '0) && !sb_c;
      zero1_q <= a_v == '0;
      ma1_q   <= sa_c ? -a_v : a_v;
      mb1_q   <= sb_c ? -b_v : b_v;
      mc1_q   <= sc_c ? -c_v : c_v;
    end
  end

  // ---------------- stage 2: products ----------------
  logic           v2_q, quad2_q, sa2_q, nb2_q, zero2_q, acneg2_q;
  logic [W-1:0]   ma2_q, mb2_q;
  logic [2*W-1:0] bb2_q, ac2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quad2_q  <= quad1_q;
      sa2_q    <= sa1_q;
      nb2_q    <= nb1_q;
      zero2_q  <= zero1_q;
      acneg2_q <= (sa1_q != sc1_q) && (mc1_q != '0);
      ma2_q    <= ma1_q;
      mb2_q    <= mb1_q;
      bb2_q    <= mb1_q * mb1_q;
      ac2_q    <= ma1_q * mc1_q;
    end
  end

  // ---------------- stage 3: discriminant ----------------
  logic [XW-1:0] bb_x, ac4_x, dm_c;
  logic          cplx_c;
  assign bb_x  = XW'(bb2_q);
  assign ac4_x = XW'({ac2_q, 2'b00});

  always_comb begin
    cplx_c = 1'b0;
    if (acneg2_q) begin
      dm_c = bb_x + ac4_x;
    end else if (bb_x >= ac4_x) begin
      dm_c = bb_x - ac4_x;
    end else begin
      dm_c   = ac4_x - bb_x;
      cplx_c = 1'b1;
    end
  end

  logic          v3_q;
  logic [XW-1:0] dm3_q;
  logic [SW-1:0] side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm3_q   <= dm_c;
      side3_q <= {quad2_q, zero2_q, sa2_q, nb2_q, (cplx_c && quad2_q), ma2_q, mb2_q};
    end
  end

  // ---------------- square root ----------------
  logic          vs;
  logic [RW-1:0] root_s;
  logic [SW-1:0] side_s;

  prs_sqrt #(.RW(RW), .SW(SW)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .x_i    (dm3_q),
    .side_i (side3_q),
    .vld_o  (vs),
    .root_o (root_s),
    .side_o (side_s)
  );

  // ---------------- numerators ----------------
  logic         q_s, z_s, sa_s, nb_s, cx_s;
  logic [W-1:0] ma_s, mb_s;
  assign {q_s, z_s, sa_s, nb_s, cx_s, ma_s, mb_s} = side_s;

  logic [MW:0]   add_p, add_m;
  logic [MW-1:0] numa_c, numb_c;
  logic          nega_c, negb_c;
  logic [DW-1:0] den_c;

  assign add_p = sm_add(nb_s, MW'(mb_s), 1'b0, MW'(root_s));
  assign add_m = sm_add(nb_s, MW'(mb_s), 1'b1, MW'(root_s));

  always_comb begin
    den_c = q_s ? DW'({ma_s, 1'b0}) : DW'(ma_s);
    if (!q_s || cx_s) begin
      numa_c = MW'(mb_s);
      nega_c = (nb_s != sa_s) && (mb_s != '0);
      numb_c = MW'(root_s);
      negb_c = sa_s && (root_s != '0);
    end else begin
      numa_c = add_p[MW-1:0];
      nega_c = (add_p[MW] != sa_s) && (add_p[MW-1:0] != '0);
      numb_c = add_m[MW-1:0];
      negb_c = (add_m[MW] != sa_s) && (add_m[MW-1:0] != '0);
    end
  end

  logic          vn_q, nega_q, negb_q;
  logic [MW-1:0] numa_q, numb_q;
  logic [DW-1:0] den_q;
  logic [2:0]    siden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en) begin
      vn_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numa_q  <= numa_c;
      numb_q  <= numb_c;
      nega_q  <= nega_c;
      negb_q  <= negb_c;
      // a zero divisor only occurs for a zero leading coefficient; keep it legal
      den_q   <= z_s ? DW'(1) : den_c;
      siden_q <= {q_s, z_s, cx_s};
    end
  end

  // ---------------- division ----------------
  logic          vd;
  logic [NW-1:0] qa_d, qb_d;
  logic [4:0]    side_d;

  prs_div #(.NW(NW), .DW(DW), .SW(5)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vn_q),
    .num_a_i (NW'(numa_q) << F),
    .num_b_i (NW'(numb_q) << F),
    .den_i   (den_q),
    .side_i  ({siden_q, nega_q, negb_q}),
    .vld_o   (vd),
    .quo_a_o (qa_d),
    .quo_b_o (qb_d),
    .side_o  (side_d)
  );

  // ---------------- output register ----------------
  logic [W:0] ra_c, rb_c;
  prs_out_t   out_d;
  assign ra_c = sat_sign(side_d[1], qa_d);
  assign rb_c = sat_sign(side_d[0], qb_d);

  always_comb begin
    out_d = '0;
    if (side_d[3]) begin
      out_d.status = StatusZeroLead;
    end else if (!side_d[4]) begin
      out_d.root_one = DataWidth'(ra_c[W-1:0]);
      out_d.status   = ra_c[W] ? StatusSat : StatusOk;
    end else begin
      out_d.root_one   = DataWidth'(ra_c[W-1:0]);
      out_d.root_two   = DataWidth'(rb_c[W-1:0]);
      out_d.is_complex = side_d[2];
      out_d.status     = (ra_c[W] || rb_c[W]) ? StatusSat : StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sim/tb.sv */
// Self-checking testbench for polynomial_root_solver_top: linear and quadratic roots.
// Depends on prs_pkg and the solver RTL; predicts each result and compares per field.
module tb;
  import prs_pkg::*;

  localparam int DW = DataWidth;
  localparam int FB = FracBits;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  prs_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  prs_out_t out_data;

  prs_out_t root_queue[$];
  int       errors;
  bit       stall_on;     // allow random receiver idling
  bit       gap_on;       // allow random sender idling
  int       hold_off;     // cycles for which the receiver holds off

  polynomial_root_solver_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Clock generation
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Truncating signed division of a magnitude, saturated to DW bits
  function automatic logic [DW-1:0] quot_sat(input bit neg, input logic [127:0] num,
                                             input logic [127:0] den, inout bit sat);
    logic [127:0] q;
    logic [127:0] lim;
    q   = num / den;
    lim = (128'd1 << (DW - 1)) - (neg ? 128'd0 : 128'd1);
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    return neg ? DW'(-q) : DW'(q);
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] b;
    r = 0;
    b = 128'd1 << 126;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Work out the roots of one equation
  function automatic prs_out_t solve_roots(input prs_in_t eq);
    prs_out_t     r;
    logic signed [127:0] a, b, c, d, num;
    logic [127:0] ma, s, mn;
    bit           sat, cplx;
    r    = '0;
    sat  = 0;
    cplx = 0;
    a  = eq.coef_a;
    b  = eq.coef_b;
    c  = eq.coef_c;
    ma = (a < 0) ? -a : a;
    if (a == 0) begin
      r.status = StatusZeroLead;
      return r;
    end
    if (!eq.func) begin
      num = -b;
      mn  = (num < 0) ? -num : num;
      r.root_one = quot_sat((num < 0) != (a < 0) && mn != 0, mn << FB, ma, sat);
    end else begin
      d = b * b - 4 * a * c;
      if (d < 0) begin
        cplx = 1;
        s    = isqrt(-d);
      end else begin
        s = isqrt(d);
      end
      if (cplx) begin
        num = -b;
        mn  = (num < 0) ? -num : num;
        r.root_one = quot_sat((num < 0) != (a < 0) && mn != 0, mn << FB, ma << 1, sat);
        r.root_two = quot_sat((a < 0) && s != 0, s << FB, ma << 1, sat);
      end else begin
        num = -b + $signed(s);
        mn  = (num < 0) ? -num : num;
        r.root_one = quot_sat((num < 0) != (a < 0) && mn != 0, mn << FB, ma << 1, sat);
        num = -b - $signed(s);
        mn  = (num < 0) ? -num : num;
        r.root_two = quot_sat((num < 0) != (a < 0) && mn != 0, mn << FB, ma << 1, sat);
      end
    end
    r.is_complex = cplx;
    r.status     = sat ? StatusSat : StatusOk;
    return r;
  endfunction

  // Offer one equation and hold it until the transfer
  task automatic send_equation(input prs_in_t eq);
    int gap;
    if (gap_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= eq;
    root_queue.push_back(solve_roots(eq));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(input bit f, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
    prs_in_t eq;
    eq.func   = f;
    eq.coef_a = a;
    eq.coef_b = b;
    eq.coef_c = c;
    send_equation(eq);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 20)) - 10 <<< FB;
      2:       return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
      3:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      4:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
    endcase
  endfunction

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (root_queue.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_fields(0, 32'h0000_0000, 32'h0001_0000, 32'h0);          // zero lead, linear
    send_fields(1, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000);  // zero lead, quadratic
    send_fields(0, 32'h0002_0000, 32'h0004_0000, 32'hffff_ffff);  // x = -2
    send_fields(0, 32'h0000_0001, 32'h7fff_ffff, 32'h0);          // saturate low
    send_fields(0, 32'h0000_0001, 32'h8000_0000, 32'h0);          // saturate other way
    send_fields(0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_fields(0, 32'h7fff_ffff, 32'h0, 32'h0);
    send_fields(1, 32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);  // roots 2 and 1
    send_fields(1, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);  // double root
    send_fields(1, 32'h0001_0000, 32'h0, 32'h0001_0000);          // purely imaginary
    send_fields(1, 32'hffff_0000, 32'h0002_0000, 32'hfffb_0000);  // complex, a negative
    send_fields(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_fields(1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_fields(1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);  // widest discriminant
    send_fields(1, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);  // saturated roots
    send_fields(1, 32'h0000_0001, 32'h0, 32'h7fff_ffff);          // saturated, complex
    send_fields(1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_fields(1, 32'h0001_0000, 32'h0, 32'h0);                  // both roots zero
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_fields($urandom_range(0, 1), rand_coef(), rand_coef(), rand_coef());
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the pipeline fills
  task automatic test_backpressure();
    hold_off = 300;
    test_random(150);
    wait (hold_off == 0);
    drain_idle();
  endtask

  task automatic test_paused_sender();
    test_random(40);
    drain_idle();
    test_random(40);
  endtask

  // Receiver: random stall bursts, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_off  = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off  = hold_off - 1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each transfer with the oldest expectation
  always @(posedge clk) begin
    prs_out_t exp_roots;
    if (rst_n && out_valid && out_ready) begin
      if (root_queue.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        exp_roots = root_queue.pop_front();
        if (out_data.root_one !== exp_roots.root_one) begin
          $error("root_one exp %h got %h", exp_roots.root_one, out_data.root_one);
          errors++;
        end
        if (out_data.root_two !== exp_roots.root_two) begin
          $error("root_two exp %h got %h", exp_roots.root_two, out_data.root_two);
          errors++;
        end
        if (out_data.is_complex !== exp_roots.is_complex) begin
          $error("is_complex exp %b got %b", exp_roots.is_complex, out_data.is_complex);
          errors++;
        end
        if (out_data.status !== exp_roots.status) begin
          $error("status exp %0d got %0d", exp_roots.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // Timeout guard
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    errors   = 0;
    stall_on = 1;
    gap_on   = 1;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_paused_sender();
    test_random(1000);
    // last stretch with no idling
    stall_on = 0;
    gap_on   = 0;
    test_random(300);
    in_valid <= 1'b0;
    while (root_queue.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/prs_pkg.sv
hw/rtl/prs_sqrt.sv
hw/rtl/prs_div.sv
hw/rtl/polynomial_root_solver_top.sv
sim/tb.sv
